// ===== rtl/core/pfba_pkg.sv =====
`default_nettype none

package pfba_pkg;

  localparam int unsigned NUM_PAGES  = 65536;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned SADDR_W = 28;
  localparam int unsigned EADDR_W = 29;
  localparam int unsigned SIZE_W  = 29;
  localparam int unsigned CNT_W   = 32;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned ROWS      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ROW_W     = $clog2(ROWS);

  // walk address: start + size plus one page step
  localparam int unsigned ADDR_W = EADDR_W + 2;
  localparam int unsigned WPG_W  = ADDR_W - PAGE_SHIFT;
  localparam int unsigned N_W    = SIZE_W + 1 - PAGE_SHIFT;
  localparam int unsigned P0_W   = SADDR_W + 1 - PAGE_SHIFT;
  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned SCAN_W = (P0_W > IDX_W + 1) ? P0_W : IDX_W + 1;
  localparam int unsigned END_W  = ((SCAN_W > N_W) ? SCAN_W : N_W) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 3'd0,
    FN_MARK   = 3'd1,
    FN_FREE   = 3'd2,
    FN_ADD    = 3'd3,
    FN_SETPTR = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK_CHK,
    ST_WALK_EV,
    ST_SCAN_CHK,
    ST_SCAN_EV,
    ST_MARK_RD,
    ST_MARK_EV,
    ST_ALLOC_FIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [ROW_W-1:0]     addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    return (b >= a) ? '0 : a - b;
  endfunction

  function automatic logic [SADDR_W-1:0] pg_to_addr(input logic [END_W-1:0] pg);
    logic [END_W+PAGE_SHIFT-1:0] w;
    w = {pg, {PAGE_SHIFT{1'b0}}};
    return w[SADDR_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [31:0] pg);
    logic [31:0] r;
    r = pg >> BIT_W;
    return r[ROW_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/page_frame_bitmap_allocator.sv =====
`default_nettype none

// Page frame allocator over a one-bit-per-page bitmap held in a single-port RAM of
// 32-page rows. A command is taken when start_i is high and busy_o is low; its one
// result beat appears with done_o high for exactly one cycle and must be taken
// then, as done_o is not held. After reset busy_o stays high while the RAM is
// filled, row by row, with all pages used. Set pointer, unused codes and zero-size
// allocations go straight to the done state. Mark, free and add region read and
// then write the row of each in-range page step and skip each out-of-range step.
// Allocate reads the row of each page scanned from the pointer, then reads and
// writes the row of each page marked; the read-modify-write through the one RAM port sets the pace.

module page_frame_bitmap_allocator
  import pfba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [SADDR_W-1:0]  start_addr_i,
  input  wire logic [EADDR_W-1:0]  range_end_i,
  input  wire logic [SIZE_W-1:0]   size_bytes_i,
  output logic [SADDR_W-1:0]       result_addr_o,
  output logic [SIZE_W-1:0]        result_size_o,
  output logic                     ok_o,
  output logic [CNT_W-1:0]         used_total_o,
  output logic [CNT_W-1:0]         usable_total_o
);

  state_e               state_q, state_d;
  logic                 set_q, set_d;
  logic [ADDR_W-1:0]    a_q, a_d;
  logic [ADDR_W-1:0]    end_q, end_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [SCAN_W-1:0]    p_q, p_d;
  logic [SCAN_W-1:0]    q_q, q_d;
  logic [N_W-1:0]       n_q, n_d;
  logic [N_W-1:0]       run_q, run_d;
  logic [END_W-1:0]     endpg_q, endpg_d;
  logic [SADDR_W-1:0]   ptr_q, ptr_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic                 ok_q, ok_d;
  logic [SADDR_W-1:0]   raddr_q, raddr_d;
  logic [SIZE_W-1:0]    rsize_q, rsize_d;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;
  logic                 init_done;

  logic [ADDR_W-1:0]    wsum;
  logic [WPG_W-1:0]     wpg;
  logic [ADDR_W-1:0]    a_step;
  logic [SIZE_W:0]      nsum;
  logic [N_W-1:0]       n_new;
  logic [SADDR_W:0]     psum;
  logic [SCAN_W-1:0]    p0_new;
  logic [WORD_BITS-1:0] idx_mask;

  pfba_bitmap u_bitmap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .rdata_o     (rdata),
    .init_done_o (init_done)
  );

  assign wsum     = a_q + ADDR_W'(PAGE_BYTES - 1);
  assign wpg      = wsum[ADDR_W-1:PAGE_SHIFT];
  assign a_step   = a_q + ADDR_W'(PAGE_BYTES);
  assign nsum     = {1'b0, size_bytes_i} + (SIZE_W + 1)'(PAGE_BYTES - 1);
  assign n_new    = nsum[SIZE_W:PAGE_SHIFT];
  assign psum     = {1'b0, ptr_q} + (SADDR_W + 1)'(PAGE_BYTES - 1);
  assign p0_new   = SCAN_W'(psum[SADDR_W:PAGE_SHIFT]);
  assign idx_mask = WORD_BITS'(1) << idx_q[BIT_W-1:0];

  always_comb begin
    state_d = state_q;
    set_d   = set_q;
    a_d     = a_q;
    end_d   = end_q;
    idx_d   = idx_q;
    p_d     = p_q;
    q_d     = q_q;
    n_d     = n_q;
    run_d   = run_q;
    endpg_d = endpg_q;
    ptr_d   = ptr_q;
    used_d  = used_q;
    total_d = total_q;
    ok_d    = ok_q;
    raddr_d = raddr_q;
    rsize_d = rsize_q;
    mem_req = '0;

    unique case (state_q)
      ST_INIT: begin
        if (init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          ok_d    = 1'b0;
          raddr_d = '0;
          rsize_d = '0;
          unique case (func_e'(func_i))
            FN_ALLOC: begin
              rsize_d = size_bytes_i;
              n_d     = n_new;
              p_d     = p0_new;
              q_d     = p0_new;
              run_d   = '0;
              if (n_new == '0) begin
                if (32'(p0_new) < NUM_PAGES) begin
                  ok_d    = 1'b1;
                  raddr_d = pg_to_addr(END_W'(p0_new));
                  ptr_d   = pg_to_addr(END_W'(p0_new));
                end
                state_d = ST_DONE;
              end else begin
                state_d = ST_SCAN_CHK;
              end
            end
            FN_MARK, FN_FREE: begin
              set_d   = (func_e'(func_i) == FN_MARK);
              a_d     = ADDR_W'(start_addr_i);
              end_d   = ADDR_W'(range_end_i);
              ok_d    = 1'b1;
              state_d = ST_WALK_CHK;
            end
            FN_ADD: begin
              total_d = sat_add(total_q, CNT_W'(size_bytes_i));
              used_d  = sat_add(used_q, CNT_W'(size_bytes_i));
              set_d   = 1'b0;
              a_d     = ADDR_W'(start_addr_i);
              end_d   = ADDR_W'(start_addr_i) + ADDR_W'(size_bytes_i);
              ok_d    = 1'b1;
              state_d = ST_WALK_CHK;
            end
            FN_SETPTR: begin
              ptr_d   = start_addr_i;
              ok_d    = 1'b1;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_WALK_CHK: begin
        if (a_q >= end_q) begin
          state_d = ST_DONE;
        end else if (32'(wpg) < NUM_PAGES) begin
          idx_d        = IDX_W'(wpg);
          mem_req.en   = 1'b1;
          mem_req.addr = row_of(32'(wpg));
          state_d      = ST_WALK_EV;
        end else begin
          // page beyond memory: skipped, command fails
          ok_d = 1'b0;
          a_d  = a_step;
        end
      end
      ST_WALK_EV: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = row_of(32'(idx_q));
        mem_req.wdata = set_q ? (rdata | idx_mask) : (rdata & ~idx_mask);
        used_d        = set_q ? sat_add(used_q, CNT_W'(PAGE_BYTES))
                              : sat_sub(used_q, CNT_W'(PAGE_BYTES));
        a_d           = a_step;
        state_d       = ST_WALK_CHK;
      end
      ST_SCAN_CHK: begin
        if (32'(p_q) >= NUM_PAGES) begin
          state_d = ST_DONE;
        end else begin
          mem_req.en   = 1'b1;
          mem_req.addr = row_of(32'(p_q));
          state_d      = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (rdata[p_q[BIT_W-1:0]]) begin
          run_d   = '0;
          q_d     = p_q + SCAN_W'(1);
          p_d     = p_q + SCAN_W'(1);
          state_d = ST_SCAN_CHK;
        end else if (32'(run_q) + 32'd1 >= 32'(n_q)) begin
          endpg_d = END_W'(q_q) + END_W'(n_q);
          idx_d   = IDX_W'(q_q);
          state_d = ST_MARK_RD;
        end else begin
          run_d   = run_q + N_W'(1);
          p_d     = p_q + SCAN_W'(1);
          state_d = ST_SCAN_CHK;
        end
      end
      ST_MARK_RD: begin
        mem_req.en   = 1'b1;
        mem_req.addr = row_of(32'(idx_q));
        state_d      = ST_MARK_EV;
      end
      ST_MARK_EV: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = row_of(32'(idx_q));
        mem_req.wdata = rdata | idx_mask;
        idx_d         = idx_q + IDX_W'(1);
        if (END_W'(idx_q) + END_W'(1) == endpg_q) begin
          state_d = ST_ALLOC_FIN;
        end else begin
          state_d = ST_MARK_RD;
        end
      end
      ST_ALLOC_FIN: begin
        used_d  = sat_add(used_q, CNT_W'(n_q) << PAGE_SHIFT);
        raddr_d = pg_to_addr(END_W'(q_q));
        ptr_d   = (32'(endpg_q) >= NUM_PAGES) ? '0 : pg_to_addr(endpg_q);
        ok_d    = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ptr_q   <= '0;
      used_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      used_q  <= used_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q   <= set_d;
    a_q     <= a_d;
    end_q   <= end_d;
    idx_q   <= idx_d;
    p_q     <= p_d;
    q_q     <= q_d;
    n_q     <= n_d;
    run_q   <= run_d;
    endpg_q <= endpg_d;
    ok_q    <= ok_d;
    raddr_q <= raddr_d;
    rsize_q <= rsize_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_DONE);
  assign result_addr_o  = raddr_q;
  assign result_size_o  = rsize_q;
  assign ok_o           = ok_q;
  assign used_total_o   = used_q;
  assign usable_total_o = total_q;

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat held for more than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  a_fail_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (result_addr_o == '0))
    else $error("failed command returned an address");

  a_no_idle_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_req.we)
    else $error("bitmap written while idle");

endmodule

`default_nettype wire

// ===== rtl/core/pfba_bitmap.sv =====
`default_nettype none

module pfba_bitmap
  import pfba_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mem_req_t             req_i,
  output logic [WORD_BITS-1:0]      rdata_o,
  output logic                      init_done_o
);

  logic [WORD_BITS-1:0] mem_q [ROWS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [ROW_W-1:0]     cnt_q, cnt_d;
  logic                 init_q, init_d;

  // fill sweep: every page starts used
  always_comb begin
    cnt_d  = cnt_q;
    init_d = init_q;
    if (init_q) begin
      if (32'(cnt_q) == ROWS - 1) begin
        init_d = 1'b0;
      end else begin
        cnt_d = cnt_q + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      init_q <= 1'b1;
    end else begin
      cnt_q  <= cnt_d;
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_q) begin
      mem_q[cnt_q] <= {WORD_BITS{1'b1}};
    end else if (req_i.en && req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o     = rdata_q;
  assign init_done_o = !init_q;

endmodule

`default_nettype wire

// ===== dv/page_frame_bitmap_allocator_tb.sv =====
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_tb;
  import pfba_pkg::*;

  localparam int unsigned WIN_PAGES   = 256;
  localparam int unsigned WIN_BASE    = (NUM_PAGES - WIN_PAGES) * PAGE_BYTES;
  localparam int unsigned WIN_BYTES   = WIN_PAGES * PAGE_BYTES;
  localparam int unsigned LAST_PAGE   = (NUM_PAGES - 1) * PAGE_BYTES;
  localparam int unsigned ADDR_MAX    = 2**SADDR_W - 1;
  localparam int unsigned END_MAX     = 2**SADDR_W;
  localparam longint unsigned CNT_FULL = 64'h0000_0000_FFFF_FFFF;
  localparam logic [FUNC_W-1:0] FN_LAST_CODE = '1;
  localparam int RANDOM_ITEMS = 370;
  localparam int QUIET_ITEMS  = 60;
  localparam int SAT_ADDS     = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 64;
  localparam int STALL_LIMIT  = 1000000;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [SADDR_W-1:0] start_addr;
    logic [EADDR_W-1:0] range_end;
    logic [SIZE_W-1:0]  size_bytes;
  } command_t;

  typedef struct packed {
    logic [SADDR_W-1:0] addr;
    logic [SIZE_W-1:0]  size;
    logic               ok;
    logic [CNT_W-1:0]   used;
    logic [CNT_W-1:0]   usable;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [FUNC_W-1:0]  func_i = '0;
  logic [SADDR_W-1:0] start_addr_i = '0;
  logic [EADDR_W-1:0] range_end_i = '0;
  logic [SIZE_W-1:0]  size_bytes_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [SADDR_W-1:0] result_addr_o;
  logic [SIZE_W-1:0]  result_size_o;
  logic               ok_o;
  logic [CNT_W-1:0]   used_total_o;
  logic [CNT_W-1:0]   usable_total_o;

  page_frame_bitmap_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .func_i         (func_i),
    .start_addr_i   (start_addr_i),
    .range_end_i    (range_end_i),
    .size_bytes_i   (size_bytes_i),
    .result_addr_o  (result_addr_o),
    .result_size_o  (result_size_o),
    .ok_o           (ok_o),
    .used_total_o   (used_total_o),
    .usable_total_o (usable_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the allocator state
  bit               page_taken [NUM_PAGES];
  logic [SADDR_W-1:0] model_ptr;
  logic [CNT_W-1:0] model_used;
  logic [CNT_W-1:0] model_usable;

  command_t pending_cmds[$];
  outcome_t awaited_results[$];
  command_t offered;
  outcome_t forecast;
  outcome_t seen;
  outcome_t want;
  bit       offer_open = 1'b0;
  bit       idle_on = 1'b1;
  int       gap_left = 0;
  int       stall_cycles = 0;
  int       mismatches = 0;
  int       cmds_taken = 0;
  int       results_checked = 0;
  int       allocs_placed = 0;
  int       allocs_refused = 0;

  function automatic logic [CNT_W-1:0] clamp_up(input logic [CNT_W-1:0] a,
                                                input longint unsigned b);
    longint unsigned s;
    s = 64'(a);
    s = s + b;
    return (s > CNT_FULL) ? CNT_FULL[CNT_W-1:0] : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] clamp_down(input logic [CNT_W-1:0] a,
                                                  input longint unsigned b);
    longint unsigned s;
    s = 64'(a);
    return (b >= s) ? '0 : a - b[CNT_W-1:0];
  endfunction

  function automatic bit walk_pages(input longint unsigned first, input longint unsigned last,
                                    input bit set_used);
    longint unsigned a;
    longint unsigned pg;
    bit all_in;
    all_in = 1'b1;
    for (a = first; a < last; a += PAGE_BYTES) begin
      pg = (a + PAGE_BYTES - 1) / PAGE_BYTES;
      if (pg >= NUM_PAGES) begin
        all_in = 1'b0;
      end else begin
        page_taken[pg] = set_used;
        model_used = set_used ? clamp_up(model_used, 64'(PAGE_BYTES))
                              : clamp_down(model_used, 64'(PAGE_BYTES));
      end
    end
    return all_in;
  endfunction

  function automatic outcome_t apply_command(input command_t c);
    outcome_t r;
    longint unsigned n, p0, q, run, p, first, span;
    bit found;
    r = '0;
    unique case (c.func)
      FN_ALLOC: begin
        r.size = c.size_bytes;
        n = 64'(c.size_bytes);
        n = (n + PAGE_BYTES - 1) / PAGE_BYTES;
        p0 = 64'(model_ptr);
        p0 = (p0 + PAGE_BYTES - 1) / PAGE_BYTES;
        q = p0;
        run = 0;
        found = 1'b0;
        if (n == 0) begin
          found = (p0 < NUM_PAGES);
        end else begin
          for (p = p0; p < NUM_PAGES && !found; p++) begin
            if (page_taken[p]) begin
              run = 0;
              q = p + 1;
            end else begin
              run++;
              if (run >= n) found = 1'b1;
            end
          end
        end
        if (found) begin
          for (p = q; p < q + n; p++) page_taken[p] = 1'b1;
          model_used = clamp_up(model_used, n * PAGE_BYTES);
          span = q * PAGE_BYTES;
          r.addr = span[SADDR_W-1:0];
          span = (q + n) * PAGE_BYTES;
          model_ptr = (n != 0 && q + n >= NUM_PAGES) ? '0 : span[SADDR_W-1:0];
          r.ok = 1'b1;
        end
      end
      FN_MARK: r.ok = walk_pages(64'(c.start_addr), 64'(c.range_end), 1'b1);
      FN_FREE: r.ok = walk_pages(64'(c.start_addr), 64'(c.range_end), 1'b0);
      FN_ADD: begin
        model_usable = clamp_up(model_usable, 64'(c.size_bytes));
        model_used = clamp_up(model_used, 64'(c.size_bytes));
        first = 64'(c.start_addr);
        r.ok = walk_pages(first, first + 64'(c.size_bytes), 1'b0);
      end
      FN_SETPTR: begin
        model_ptr = c.start_addr;
        r.ok = 1'b1;
      end
      default: r.ok = 1'b0;
    endcase
    r.used = model_used;
    r.usable = model_usable;
    return r;
  endfunction

  // command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      offer_open = 1'b0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o) begin
        forecast = apply_command(offered);
        awaited_results.push_back(forecast);
        if (offered.func == FN_ALLOC) begin
          if (forecast.ok) allocs_placed++;
          else allocs_refused++;
        end
        cmds_taken++;
        offer_open = 1'b0;
      end
      if (!offer_open) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          offered = pending_cmds.pop_front();
          offer_open = 1'b1;
          start_i <= 1'b1;
          func_i <= offered.func;
          start_addr_i <= offered.start_addr;
          range_end_i <= offered.range_end;
          size_bytes_i <= offered.size_bytes;
          if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 18);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done_o) begin
        seen = {result_addr_o, result_size_o, ok_o, used_total_o, usable_total_o};
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result beat with nothing awaited: addr %h size %h ok %b used %h usable %h",
                     seen.addr, seen.size, seen.ok, seen.used, seen.usable);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (seen.addr !== want.addr || seen.size !== want.size || seen.ok !== want.ok ||
              seen.used !== want.used || seen.usable !== want.usable) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d: expected addr %h size %h ok %b used %h usable %h",
                       results_checked, want.addr, want.size, want.ok, want.used, want.usable);
              $display("result %0d:      got addr %h size %h ok %b used %h usable %h",
                       results_checked, seen.addr, seen.size, seen.ok, seen.used, seen.usable);
            end
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("page_frame_bitmap_allocator_tb: FAIL");
    $finish;
  end

  task automatic push_cmd(input logic [FUNC_W-1:0] f, input int unsigned s,
                          input int unsigned e, input int unsigned z);
    pending_cmds.push_back(command_t'{f, SADDR_W'(s), EADDR_W'(e), SIZE_W'(z)});
  endtask

  task automatic settle();
    while (pending_cmds.size() != 0 || offer_open || awaited_results.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic int unsigned window_addr();
    return WIN_BASE + $urandom_range(0, WIN_BYTES - 1);
  endfunction

  function automatic int unsigned spare_field();
    return $urandom_range(0, END_MAX);
  endfunction

  // keeps every scan inside the top window so it stays short
  task automatic alloc_from_window(input int unsigned z);
    while (pending_cmds.size() != 0 || offer_open) @(posedge clk_i);
    if (model_ptr < WIN_BASE) push_cmd(FN_SETPTR, window_addr(), spare_field(), spare_field());
    push_cmd(FN_ALLOC, $urandom_range(0, ADDR_MAX), spare_field(), z);
  endtask

  initial begin
    int pick;
    int sel;
    longint unsigned wide;
    logic [FUNC_W-1:0] f;
    int unsigned s;
    int unsigned e;
    int unsigned z;

    foreach (page_taken[p]) page_taken[p] = 1'b1;
    model_ptr = '0;
    model_used = '0;
    model_usable = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    push_cmd(FN_FREE, 0, PAGE_BYTES, spare_field());
    push_cmd(FN_ADD, WIN_BASE, spare_field(), WIN_BYTES);
    push_cmd(FN_SETPTR, WIN_BASE + 1, spare_field(), spare_field());
    push_cmd(FN_ALLOC, 0, spare_field(), 0);
    push_cmd(FN_ALLOC, 0, spare_field(), 1);
    push_cmd(FN_ALLOC, 0, spare_field(), PAGE_BYTES + 1);
    push_cmd(FN_MARK, WIN_BASE + 16 * PAGE_BYTES, WIN_BASE + 19 * PAGE_BYTES, spare_field());
    push_cmd(FN_ALLOC, 0, spare_field(), 32 * PAGE_BYTES);
    push_cmd(FN_SETPTR, LAST_PAGE, spare_field(), spare_field());
    push_cmd(FN_ALLOC, 0, spare_field(), PAGE_BYTES);
    push_cmd(FN_ALLOC, 0, spare_field(), PAGE_BYTES);
    push_cmd(FN_SETPTR, ADDR_MAX, spare_field(), spare_field());
    push_cmd(FN_ALLOC, ADDR_MAX, END_MAX, END_MAX);
    push_cmd(FN_ALLOC, 0, spare_field(), 0);
    push_cmd(FN_SETPTR, WIN_BASE, spare_field(), spare_field());
    push_cmd(FN_ALLOC, 0, spare_field(), ADDR_MAX);
    push_cmd(FN_MARK, LAST_PAGE + 1, END_MAX, spare_field());
    push_cmd(FN_FREE, ADDR_MAX, END_MAX, spare_field());
    push_cmd(FN_ADD, LAST_PAGE - PAGE_BYTES, spare_field(), 3 * PAGE_BYTES);
    push_cmd(FN_MARK, 100, 50, spare_field());
    push_cmd(FN_FREE, WIN_BASE + PAGE_BYTES, WIN_BASE + PAGE_BYTES, spare_field());
    push_cmd(FN_FREE, WIN_BASE + 'h800, WIN_BASE + 'h2800, spare_field());
    push_cmd(FN_ADD, WIN_BASE, spare_field(), 0);
    for (int c = int'(FN_SETPTR) + 1; c <= int'(FN_LAST_CODE); c++)
      push_cmd(FUNC_W'(c), $urandom_range(0, ADDR_MAX), spare_field(), spare_field());
    settle();

    // random mix, mostly inside the window
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) z = 0;
        else if (sel == 1) z = $urandom_range(0, ADDR_MAX);
        else z = $urandom_range(1, 8 * PAGE_BYTES);
        alloc_from_window(z);
      end else if (pick < 75) begin
        f = (pick < 55) ? FN_FREE : FN_MARK;
        s = ($urandom_range(0, 3) != 0) ? window_addr() : $urandom_range(0, ADDR_MAX);
        if ($urandom_range(0, 7) == 0) begin
          e = $urandom_range(0, s);
        end else begin
          wide = 64'(s);
          wide = wide + 64'($urandom_range(1, 16 * PAGE_BYTES));
          e = (wide > END_MAX) ? END_MAX : wide[31:0];
        end
        push_cmd(f, s, e, spare_field());
      end else if (pick < 88) begin
        sel = $urandom_range(0, 19);
        if (sel < 12) s = window_addr();
        else if (sel < 17) s = $urandom_range(0, ADDR_MAX);
        else s = ADDR_MAX - $urandom_range(0, 8 * PAGE_BYTES);
        push_cmd(FN_ADD, s, spare_field(), $urandom_range(0, 16 * PAGE_BYTES));
      end else if (pick < 96) begin
        s = ($urandom_range(0, 2) != 0) ? window_addr() : $urandom_range(0, ADDR_MAX);
        push_cmd(FN_SETPTR, s, spare_field(), spare_field());
      end else begin
        push_cmd(FUNC_W'($urandom_range(int'(FN_SETPTR) + 1, int'(FN_LAST_CODE))),
                 $urandom_range(0, ADDR_MAX), spare_field(), spare_field());
      end
    end
    settle();

    // drive both counters into saturation, then a little traffic on top
    for (int k = 0; k < SAT_ADDS; k++) push_cmd(FN_ADD, ADDR_MAX, spare_field(), END_MAX);
    push_cmd(FN_FREE, WIN_BASE, WIN_BASE + 2 * PAGE_BYTES, spare_field());
    push_cmd(FN_MARK, WIN_BASE, WIN_BASE + PAGE_BYTES, spare_field());
    alloc_from_window(PAGE_BYTES);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("page_frame_bitmap_allocator_tb: %0d commands, %0d results checked, %0d mismatches",
             cmds_taken, results_checked, mismatches);
    $display("allocations placed %0d, refused %0d; final used %h, usable %h",
             allocs_placed, allocs_refused, model_used, model_usable);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("page_frame_bitmap_allocator_tb: PASS");
    end else begin
      $display("page_frame_bitmap_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
